### hdl/klsh_pkg.sv
package klsh_pkg;

	localparam int MAX_K       = 32;
	localparam int MAX_PLANES  = 16;
	localparam int COEF_BITS   = 16;
	localparam int K_W         = $clog2(MAX_K);
	localparam int P_W         = $clog2(MAX_PLANES);
	localparam int STORE_DEPTH = MAX_PLANES * MAX_K;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int CODE_W      = 3;
	localparam int PROD_W      = COEF_BITS + CODE_W;
	localparam int ACC_W       = PROD_W + K_W + 1;
	localparam int FILL_W      = K_W + 1;
	localparam int HASH_W      = 16;
	localparam int CFG_W       = 6;
	localparam int QDEPTH      = 2;

	localparam logic [0:0] OP_COEF = 1'b0;
	localparam logic [0:0] OP_BASE = 1'b1;

	localparam logic [0:0] REG_KMER_LENGTH   = 1'b0;
	localparam logic [0:0] REG_PLANES_IN_USE = 1'b1;

	// job handed from front to back: one full window to hash
	typedef struct packed {
		logic [MAX_K*CODE_W-1:0] window;  // index 0 = newest code
		logic [K_W-1:0]          klast;   // effective k minus one
		logic [P_W:0]            planes;  // active plane count
	} job_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_RUN,
		BK_DRAIN,
		BK_OUT
	} bk_state_t;

	// case-folded nucleotide code in half units
	function automatic logic signed [CODE_W-1:0] encode_base(input logic [7:0] ch);
		logic [7:0] c;
		c = (ch >= 8'h61 && ch <= 8'h7a) ? ch - 8'd32 : ch;
		unique case (c)
			8'h41:   encode_base = 3'sd2;
			8'h43:   encode_base = 3'sd1;
			8'h47:   encode_base = -3'sd1;
			8'h54:   encode_base = -3'sd2;
			default: encode_base = 3'sd0;
		endcase
	endfunction

endpackage

### hdl/kmer_hyperplane_lsh_hash_top.sv
// k-mer hyperplane hash. A coefficient write (op 0) gives no result. It waits
// while any hash job is queued or still reading the coefficient memory, so
// every hash sees the coefficients as they stood when its base was taken. A
// base (op 1) shifts into the window. Once the window holds k bases, the base
// yields a hash, computed from planes*k reads of the single coefficient
// memory port, which is read once per cycle. A two-deep job queue lets later
// bases enter while a hash is computed. Coefficients never written read as
// undefined.
module kmer_hyperplane_lsh_hash_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // plane_index, coef_position, coef_value, base_char
	input  logic [1:0]  s_tuser,   // op, read_start
	input  logic        m_tready,
	output logic        m_tvalid,
	output logic [15:0] m_tdata,   // hash_value
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [5:0]  cfg_wdata
);
	import klsh_pkg::*;

	logic [5:0] kmer_length_q;
	logic [4:0] planes_in_use_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kmer_length_q   <= 6'd16;
			planes_in_use_q <= 5'd16;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KMER_LENGTH:   kmer_length_q   <= cfg_wdata;
				REG_PLANES_IN_USE: planes_in_use_q <= cfg_wdata[4:0];
				default: ;
			endcase
		end
	end

	logic                  coef_we;
	logic [ADDR_W-1:0]     coef_waddr, coef_raddr;
	logic [COEF_BITS-1:0]  coef_wdata, coef_rdata;
	logic                  fj_valid, fj_ready, bj_valid, bj_ready;
	job_t                  fj, bj;
	logic                  back_busy;
	logic                  store_busy;

	// coefficient memory still needed by a queued or running job
	assign store_busy = bj_valid || back_busy;

	klsh_front u_front (
		.clk, .arst_n,
		.in_valid(s_tvalid), .in_ready(s_tready),
		.op(s_tuser[0]), .plane_index(s_tdata[3:0]), .coef_position(s_tdata[8:4]),
		.coef_value(s_tdata[24:9]), .base_char(s_tdata[32:25]), .read_start(s_tuser[1]),
		.kmer_length(kmer_length_q), .planes_in_use(planes_in_use_q),
		.store_busy,
		.coef_we, .coef_waddr, .coef_wdata,
		.job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
	);

	klsh_queue u_queue (
		.clk, .arst_n,
		.push_valid(fj_valid), .push_ready(fj_ready), .push_data(fj),
		.pop_valid(bj_valid), .pop_ready(bj_ready), .pop_data(bj)
	);

	klsh_ram #(.WIDTH(COEF_BITS), .DEPTH(STORE_DEPTH)) u_coef (
		.clk, .we(coef_we), .waddr(coef_waddr), .wdata(coef_wdata),
		.raddr(coef_raddr), .rdata(coef_rdata)
	);

	klsh_back u_back (
		.clk, .arst_n,
		.job_valid(bj_valid), .job_ready(bj_ready), .job(bj),
		.busy(back_busy),
		.coef_raddr, .coef_rdata,
		.out_valid(m_tvalid), .out_ready(m_tready), .hash_value(m_tdata)
	);

	logic unused_tdata;
	assign unused_tdata = ^s_tdata[39:33];

endmodule

### hdl/klsh_ram.sv
module klsh_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### hdl/klsh_front.sv
module klsh_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             op,
	input  logic [3:0]                       plane_index,
	input  logic [4:0]                       coef_position,
	input  logic signed [15:0]               coef_value,
	input  logic [7:0]                       base_char,
	input  logic                             read_start,
	input  logic [5:0]                       kmer_length,
	input  logic [4:0]                       planes_in_use,
	input  logic                             store_busy,
	output logic                             coef_we,
	output logic [klsh_pkg::ADDR_W-1:0]      coef_waddr,
	output logic [klsh_pkg::COEF_BITS-1:0]   coef_wdata,
	output logic                             job_valid,
	input  logic                             job_ready,
	output klsh_pkg::job_t                   job
);
	import klsh_pkg::*;

	logic [MAX_K*CODE_W-1:0] win_q;
	logic [FILL_W-1:0]       fill_q;
	logic [MAX_K*CODE_W-1:0] win_next;
	logic [FILL_W-1:0]       fill_base;
	logic [FILL_W-1:0]       fill_next;
	logic [FILL_W-1:0]       k_eff;
	logic [P_W:0]            np_eff;
	logic                    take;
	logic                    is_base;
	logic                    emit;

	assign is_base  = (op == OP_BASE);
	// a coefficient write waits until no job needs the store; a base waits
	// only when it makes a job and the queue is full
	assign in_ready = is_base ? (!emit || job_ready) : !store_busy;
	assign take     = in_valid && in_ready;

	// coefficient store write
	assign coef_we    = take && !is_base;
	assign coef_waddr = ADDR_W'({plane_index, coef_position});
	assign coef_wdata = COEF_BITS'(coef_value);

	// effective k and plane count
	always_comb begin
		if (kmer_length == 6'd0) begin
			k_eff = FILL_W'(1);
		end else if (kmer_length > 6'(MAX_K)) begin
			k_eff = FILL_W'(MAX_K);
		end else begin
			k_eff = FILL_W'(kmer_length);
		end
		if (planes_in_use > 5'(MAX_PLANES)) begin
			np_eff = (P_W+1)'(MAX_PLANES);
		end else begin
			np_eff = (P_W+1)'(planes_in_use);
		end
	end

	// window shift with optional clear at read start
	always_comb begin
		win_next  = read_start ? '0 : win_q;
		fill_base = read_start ? '0 : fill_q;
		win_next  = {win_next[(MAX_K-1)*CODE_W-1:0], encode_base(base_char)};
		fill_next = (fill_base < FILL_W'(MAX_K)) ? fill_base + 1'b1 : fill_base;
	end

	assign emit = (fill_next >= k_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q  <= '0;
			fill_q <= '0;
		end else if (take && is_base) begin
			win_q  <= win_next;
			fill_q <= fill_next;
		end
	end

	assign job_valid    = in_valid && is_base && emit;
	assign job.window   = win_next;
	assign job.klast    = K_W'(k_eff - 1'b1);
	assign job.planes   = np_eff;

endmodule

### hdl/klsh_queue.sv
module klsh_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  klsh_pkg::job_t push_data,
	output logic           pop_valid,
	input  logic           pop_ready,
	output klsh_pkg::job_t pop_data
);
	import klsh_pkg::*;

	localparam int IW = $clog2(QDEPTH);

	job_t          slot_q [QDEPTH];
	logic [IW-1:0] wr_q;
	logic [IW-1:0] rd_q;
	logic [IW:0]   cnt_q;
	logic          push;
	logic          pop;

	assign push_ready = (cnt_q != (IW+1)'(QDEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_data;
		end
	end

	// pointer and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == IW'(QDEPTH-1)) ? '0 : wr_q + 1'b1;
			if (pop)  rd_q <= (rd_q == IW'(QDEPTH-1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + (IW+1)'(push) - (IW+1)'(pop);
		end
	end

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (IW+1)'(QDEPTH)) else $error("queue count overflow");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |-> !pop) else $error("pop from empty queue");
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (cnt_q == $past(cnt_q) + 1'b1)) else $error("count step");
`endif

endmodule

### hdl/klsh_back.sv
module klsh_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           job_valid,
	output logic                           job_ready,
	input  klsh_pkg::job_t                 job,
	output logic                           busy,
	output logic [klsh_pkg::ADDR_W-1:0]    coef_raddr,
	input  logic [klsh_pkg::COEF_BITS-1:0] coef_rdata,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [15:0]                    hash_value
);
	import klsh_pkg::*;

	bk_state_t state_q, state_nx;

	job_t                        job_q;
	logic [K_W-1:0]              pos_q;     // coefficient position being read
	logic [P_W-1:0]              plane_q;   // plane being read
	logic                        rd_s1;     // coefficient read data valid this cycle
	logic [K_W-1:0]              pos_s1;
	logic [P_W-1:0]              plane_s1;
	logic                        last_s1;   // last term of a plane
	logic signed [ACC_W-1:0]     acc_q [MAX_PLANES];
	logic [HASH_W-1:0]           hash_q;
	logic signed [CODE_W-1:0]    code_s1;
	logic signed [PROD_W-1:0]    prod;
	logic                        issue;
	logic                        pos_end;
	logic                        plane_end;
	logic [K_W-1:0]              widx;

	// position j reads window code at index k-1-j (oldest first)
	assign widx    = K_W'(job_q.klast - pos_s1);
	assign code_s1 = job_q.window[widx*CODE_W +: CODE_W];
	assign prod    = PROD_W'($signed(coef_rdata)) * PROD_W'(code_s1);

	assign pos_end   = (pos_q == job_q.klast);
	assign plane_end = ((P_W+1)'(plane_q) + 1'b1 >= job_q.planes);

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			BK_IDLE:  if (job_valid) state_nx = (job.planes == '0) ? BK_OUT : BK_RUN;
			BK_RUN:   if (pos_end && plane_end) state_nx = BK_DRAIN;
			BK_DRAIN: state_nx = BK_OUT;
			BK_OUT:   if (out_ready) state_nx = BK_IDLE;
			default:  state_nx = BK_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		job_ready = (state_q == BK_IDLE);
		issue     = (state_q == BK_RUN);
		out_valid = (state_q == BK_OUT);
		busy      = (state_q == BK_RUN) || (state_q == BK_DRAIN);
	end

	assign coef_raddr = ADDR_W'({plane_q, pos_q});
	assign hash_value = hash_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			rd_s1   <= 1'b0;
		end else begin
			state_q <= state_nx;
			rd_s1   <= issue;
		end
	end

	// sequencer: one coefficient read per cycle, planes one after another
	always_ff @(posedge clk) begin
		if (job_ready && job_valid) begin
			job_q   <= job;
			pos_q   <= '0;
			plane_q <= '0;
			hash_q  <= '0;
		end else if (issue) begin
			if (pos_end) begin
				pos_q   <= '0;
				plane_q <= plane_q + 1'b1;
			end else begin
				pos_q <= pos_q + 1'b1;
			end
		end
		pos_s1   <= pos_q;
		plane_s1 <= plane_q;
		last_s1  <= pos_end;
		// accumulate; the newest position is subtracted
		if (rd_s1) begin
			if (pos_s1 == '0) begin
				acc_q[plane_s1] <= (pos_s1 == job_q.klast) ? -ACC_W'(prod) : ACC_W'(prod);
			end else if (pos_s1 == job_q.klast) begin
				acc_q[plane_s1] <= acc_q[plane_s1] - ACC_W'(prod);
			end else begin
				acc_q[plane_s1] <= acc_q[plane_s1] + ACC_W'(prod);
			end
		end
		// sign test of a finished plane
		if (rd_s1 && last_s1 && (32'(plane_s1) < HASH_W)) begin
			if (pos_s1 == '0) begin
				hash_q[plane_s1] <= (-ACC_W'(prod)) > 0;
			end else begin
				hash_q[plane_s1] <= (acc_q[plane_s1] - ACC_W'(prod)) > 0;
			end
		end
	end

`ifndef SYNTHESIS
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> $stable(hash_value)) else $error("hash changed");
	a_no_rd_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_IDLE) |-> !issue) else $error("read while idle");
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_DRAIN) |-> rd_s1) else $error("drain without data");
`endif

endmodule
